// ===== rtl/i2cm_pkg.sv =====
// Package for the I2C master byte engine: operation codes, field widths
// and the item and result structs shared by the engine core and the top level.
// No dependencies.
`default_nettype none

package i2cm_pkg;

	localparam int UNIT_W    = 10;
	localparam int DELAY_W   = 12;
	localparam int BYTE_W    = 8;
	localparam int OP_W      = 3;
	localparam int BITCNT_W  = 4;
	localparam int POLL_W    = 8;
	localparam int POLL_LIMIT_DEF = 250;

	localparam logic [UNIT_W-1:0] UNIT_DELAY_RST = UNIT_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4,
		OP_WACK  = 3'd5
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [BYTE_W-1:0] write_data;
		logic              send_ack;
		logic              sda_in;
	} cmd_t;

	typedef struct packed {
		logic              scl_out;
		logic              sda_out;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_data;
		logic              ack_failed;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/i2cm_if.sv =====
// Valid/ready channel interfaces for command beats, result beats and
// configuration writes. Depends on i2cm_pkg.
`default_nettype none

interface i2cm_cmd_if
	import i2cm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [BYTE_W-1:0] write_data;
	logic              send_ack;
	logic              sda_in;

	modport source (output valid, output operation, output write_data,
		output send_ack, output sda_in, input ready);
	modport sink (input valid, input operation, input write_data,
		input send_ack, input sda_in, output ready);
endinterface

interface i2cm_res_if
	import i2cm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              scl_out;
	logic              sda_out;
	logic              busy_res;
	logic              done_res;
	logic [BYTE_W-1:0] read_data;
	logic              ack_failed;

	modport source (output valid, output scl_out, output sda_out, output busy_res,
		output done_res, output read_data, output ack_failed, input ready);
	modport sink (input valid, input scl_out, input sda_out, input busy_res,
		input done_res, input read_data, input ack_failed, output ready);
endinterface

interface i2cm_cfg_if
	import i2cm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] unit_delay;

	modport source (output valid, output unit_delay, input ready);
	modport sink (input valid, input unit_delay, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cm_core.sv =====
// Bus sequencer of the I2C master: phase state, delay, bit and poll counters,
// shift register and driven line levels, advanced once per accepted beat.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_core
	import i2cm_pkg::*;
#(
	parameter int POLL_LIMIT = POLL_LIMIT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [UNIT_W-1:0] unit_delay,
	input  wire cmd_t              cmd,
	output res_t                   res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WR_SETUP, PH_WR_HIGH,
		PH_WR_LOW, PH_RD_LOW, PH_RD_HIGH, PH_AK_LOW, PH_AK_HIGH, PH_WA_A,
		PH_WA_B, PH_WA_POLL
	} phase_t;

	localparam logic [POLL_W-1:0]   POLL_MAX = POLL_W'(POLL_LIMIT);
	localparam logic [BITCNT_W-1:0] BITS     = BITCNT_W'(BYTE_W);

	phase_t              phase_q, phase_d;
	logic [BITCNT_W-1:0] bitcnt_q, bitcnt_d, bitcnt_inc;
	logic [BYTE_W-1:0]   shift_q, shift_d;
	logic [DELAY_W-1:0]  dly_q, dly_d, dly_dec;
	logic [POLL_W-1:0]   poll_q, poll_d;
	logic                scl_q, scl_d, sda_q, sda_d;
	logic                ackm_q, ackm_d, tmo_q, tmo_d;
	logic [BYTE_W-1:0]   rx_q, rx_d;
	logic                done;
	logic [UNIT_W-1:0]   unit;
	logic [DELAY_W-1:0]  d1, d2, d4;

	// zero unit delay counts as one
	assign unit = (unit_delay == '0) ? UNIT_W'(1) : unit_delay;
	assign d1   = DELAY_W'(unit);
	assign d2   = DELAY_W'({unit, 1'b0});
	assign d4   = DELAY_W'({unit, 2'b00});

	assign dly_dec    = (dly_q != '0) ? dly_q - DELAY_W'(1) : dly_q;
	assign bitcnt_inc = bitcnt_q + BITCNT_W'(1);

	always_comb begin
		phase_d  = phase_q;
		bitcnt_d = bitcnt_q;
		shift_d  = shift_q;
		dly_d    = dly_q;
		poll_d   = poll_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		ackm_d   = ackm_q;
		tmo_d    = tmo_q;
		rx_d     = rx_q;
		done     = 1'b0;
		if (phase_q == PH_IDLE) begin
			case (cmd.operation)
				OP_START: begin
					sda_d = 1'b1; scl_d = 1'b1; dly_d = d4; phase_d = PH_ST_A;
				end
				OP_STOP: begin
					scl_d = 1'b0; sda_d = 1'b0; dly_d = d4; phase_d = PH_SP_A;
				end
				OP_WRITE: begin
					scl_d = 1'b0; bitcnt_d = '0;
					sda_d = cmd.write_data[BYTE_W-1];
					shift_d = {cmd.write_data[BYTE_W-2:0], 1'b0};
					dly_d = d2; phase_d = PH_WR_SETUP;
				end
				OP_READ: begin
					sda_d = 1'b1; scl_d = 1'b0; bitcnt_d = '0; shift_d = '0;
					ackm_d = cmd.send_ack; dly_d = d2; phase_d = PH_RD_LOW;
				end
				OP_WACK: begin
					sda_d = 1'b1; poll_d = '0; tmo_d = 1'b0;
					dly_d = d1; phase_d = PH_WA_A;
				end
				default: ;
			endcase
		end else if (phase_q == PH_WA_POLL || (phase_q == PH_WA_B && dly_dec == '0)) begin
			// poll SDA once per beat: low is an ack, too many highs end in a stop
			if (phase_q == PH_WA_B) dly_d = dly_dec;
			phase_d = PH_WA_POLL;
			if (!cmd.sda_in) begin
				scl_d = 1'b0; tmo_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
			end else if (poll_q >= POLL_MAX) begin
				tmo_d = 1'b1;
				scl_d = 1'b0; sda_d = 1'b0; dly_d = d4; phase_d = PH_SP_A;
			end else begin
				poll_d = poll_q + POLL_W'(1);
			end
		end else begin
			dly_d = dly_dec;
			if (dly_dec == '0) begin
				case (phase_q)
					PH_ST_A: begin
						sda_d = 1'b0; dly_d = d4; phase_d = PH_ST_B;
					end
					PH_ST_B: begin
						scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
					end
					PH_SP_A: begin
						scl_d = 1'b1; sda_d = 1'b1; dly_d = d4; phase_d = PH_SP_B;
					end
					PH_SP_B: begin
						phase_d = PH_IDLE; done = 1'b1;
					end
					PH_WR_SETUP: begin
						scl_d = 1'b1; dly_d = d2; phase_d = PH_WR_HIGH;
					end
					PH_WR_HIGH: begin
						scl_d = 1'b0; dly_d = d2; phase_d = PH_WR_LOW;
					end
					PH_WR_LOW: begin
						bitcnt_d = bitcnt_inc;
						if (bitcnt_inc >= BITS) begin
							phase_d = PH_IDLE; done = 1'b1;
						end else begin
							sda_d = shift_q[BYTE_W-1];
							shift_d = {shift_q[BYTE_W-2:0], 1'b0};
							dly_d = d2; phase_d = PH_WR_SETUP;
						end
					end
					PH_RD_LOW: begin
						scl_d = 1'b1;
						shift_d = {shift_q[BYTE_W-2:0], cmd.sda_in};
						dly_d = d1; phase_d = PH_RD_HIGH;
					end
					PH_RD_HIGH: begin
						bitcnt_d = bitcnt_inc; scl_d = 1'b0; dly_d = d2;
						if (bitcnt_inc < BITS) begin
							phase_d = PH_RD_LOW;
						end else begin
							sda_d = !ackm_q; phase_d = PH_AK_LOW;
						end
					end
					PH_AK_LOW: begin
						scl_d = 1'b1; dly_d = d2; phase_d = PH_AK_HIGH;
					end
					PH_AK_HIGH: begin
						scl_d = 1'b0; rx_d = shift_q; phase_d = PH_IDLE; done = 1'b1;
					end
					PH_WA_A: begin
						scl_d = 1'b1; dly_d = d1; phase_d = PH_WA_B;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bitcnt_q <= '0;
			shift_q  <= '0;
			dly_q    <= '0;
			poll_q   <= '0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			ackm_q   <= 1'b0;
			tmo_q    <= 1'b0;
			rx_q     <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			bitcnt_q <= bitcnt_d;
			shift_q  <= shift_d;
			dly_q    <= dly_d;
			poll_q   <= poll_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
			ackm_q   <= ackm_d;
			tmo_q    <= tmo_d;
			rx_q     <= rx_d;
		end
	end

	always_comb begin
		res.scl_out    = scl_d;
		res.sda_out    = sda_d;
		res.busy_res   = (phase_d != PH_IDLE);
		res.done_res   = done;
		res.read_data  = rx_d;
		res.ack_failed = tmo_d;
	end

`ifndef SYNTH
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.done_res |-> !res.busy_res)
		else $error("done raised while still busy");
	a_write_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_IDLE && cmd.operation == OP_WRITE
		|=> phase_q == PH_WR_SETUP && !scl_q)
		else $error("write byte did not enter its setup phase");
	a_poll_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WA_POLL |-> scl_q)
		else $error("SCL low while polling for ack");
	a_bitcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bitcnt_q <= BITS)
		else $error("bit counter past a byte");
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q) && $stable(dly_q))
		else $error("sequencer moved without a beat");
`endif

endmodule

`default_nettype wire

// ===== rtl/i2c_master_byte_engine_unit.sv =====
// Top level of the I2C master byte engine: configuration register, engine
// core and result output register. Depends on i2cm_pkg, the channel
// interfaces and i2cm_core.
//
// Each command beat is one bus tick: a start, stop, write byte, read byte or
// wait ack beat begins a sequence when the engine is idle, any other beat
// (and any command while busy) just advances the running sequence by one
// tick. Every accepted beat yields exactly one result beat carrying the SCL
// and SDA levels to drive (1 means released), busy and done flags, the last
// received byte and the ack timeout flag. The engine takes one beat per
// clock; the result of a beat appears in the output register on the next
// clock and a new command beat is taken in the same cycle that the held
// result is taken, so a stalled result sink only pauses the command side.
// Bus phase lengths are multiples of unit_delay ticks (0 counts as 1); write
// unit_delay only while no sequence is in progress.
`default_nettype none

module i2c_master_byte_engine_unit
	import i2cm_pkg::*;
#(
	parameter int POLL_LIMIT = POLL_LIMIT_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	i2cm_cmd_if.sink    cmd,
	i2cm_res_if.source  res,
	i2cm_cfg_if.sink    cfg
);

	logic              accept;
	logic [UNIT_W-1:0] unit_delay_q;
	cmd_t              cmd_beat;
	res_t              res_next;
	res_t              res_q;
	logic              res_valid_q;

	// configuration is always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_delay_q <= UNIT_DELAY_RST;
		end else if (cfg.valid) begin
			unit_delay_q <= cfg.unit_delay;
		end
	end

	// take a command beat when the output register is empty or being drained
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		cmd_beat.operation  = cmd.operation;
		cmd_beat.write_data = cmd.write_data;
		cmd_beat.send_ack   = cmd.send_ack;
		cmd_beat.sda_in     = cmd.sda_in;
	end

	i2cm_core #(
		.POLL_LIMIT (POLL_LIMIT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.unit_delay (unit_delay_q),
		.cmd        (cmd_beat),
		.res        (res_next)
	);

	// hold the result until the sink takes it; load a new one on every accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_next;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.scl_out    = res_q.scl_out;
	assign res.sda_out    = res_q.sda_out;
	assign res.busy_res   = res_q.busy_res;
	assign res.done_res   = res_q.done_res;
	assign res.read_data  = res_q.read_data;
	assign res.ack_failed = res_q.ack_failed;

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res_q))
		else $error("result dropped while stalled");
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res.valid)
		else $error("accepted beat gave no result");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |-> !cmd.ready)
		else $error("command taken over a held result");
`endif

endmodule

`default_nettype wire

// ===== sim/i2c_master_byte_engine_unit_tb.sv =====
// Self-checking testbench for i2c_master_byte_engine_unit: drives command beats,
// predicts every result beat with its own bus timing model and compares them.
// Depends on i2cm_pkg, the channel interfaces and the engine top level.
`default_nettype none

module i2c_master_byte_engine_unit_tb;
	import i2cm_pkg::*;

	// Unused operation codes: the engine must treat them as plain ticks.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_BEATS  = 400;
	localparam int LONG_UNIT     = 100;  // long delay unit for the stretched wait ack
	localparam int LONG_HOLD     = 400;  // receiver hold-off, in cycles
	localparam int STALL_LIMIT   = 2000; // cycles without any beat before giving up
	localparam int SETTLE_CYCLES = 4;

	// Bus phases of the predictor.
	typedef enum logic [4:0] {
		BP_IDLE,
		BP_STA_HIGH,   // start: both lines high, then SDA falls
		BP_STA_LOW,    // start: SDA low, then SCL falls
		BP_STO_LOW,    // stop: both low, then both released
		BP_STO_HIGH,   // stop: both high until done
		BP_WR_DATA,    // write: data bit set up with SCL low
		BP_WR_SCLH,
		BP_WR_SCLL,
		BP_RD_SCLL,
		BP_RD_SCLH,
		BP_ACK_SCLL,   // read: acknowledge bit driven
		BP_ACK_SCLH,
		BP_WAIT_SETUP, // wait ack: SDA released, SCL left as it was
		BP_WAIT_SCLH,
		BP_WAIT_POLL
	} bus_phase_t;

	logic clk = 1'b0;
	logic arst_n;

	i2cm_cmd_if cmd_ch();
	i2cm_res_if res_ch();
	i2cm_cfg_if cfg_ch();

	i2c_master_byte_engine_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// Predictor state, a private copy of the engine's registers.
	bus_phase_t           bus_phase;
	logic [UNIT_W-1:0]    unit_q;
	logic [BITCNT_W-1:0]  bits_done;
	logic [BYTE_W-1:0]    shift_q;
	logic [DELAY_W-1:0]   ticks_left;
	logic [POLL_W-1:0]    polls_seen;
	logic                 scl_q;
	logic                 sda_q;
	logic                 ack_low_q;
	logic                 timeout_q;
	logic [BYTE_W-1:0]    rx_byte_q;

	res_t bus_state_q[$];  // predicted result beats, oldest first
	int   errors;
	int   active_beats;    // beats that start or advance a sequence
	bit   jitter_on;       // random gaps on both channels
	bit   hold_off_req;    // ask the receiver for one long hold-off

	function automatic void reset_model();
		bus_phase  = BP_IDLE;
		unit_q     = UNIT_DELAY_RST;
		bits_done  = '0;
		shift_q    = '0;
		ticks_left = '0;
		polls_seen = '0;
		scl_q      = 1'b1;
		sda_q      = 1'b1;
		ack_low_q  = 1'b0;
		timeout_q  = 1'b0;
		rx_byte_q  = '0;
	endfunction

	// Load a phase length of the given number of delay units; zero counts as one.
	function automatic void load_ticks(input int units);
		logic [UNIT_W-1:0] u;
		u = (unit_q == '0) ? UNIT_W'(1) : unit_q;
		ticks_left = DELAY_W'(units * u);
	endfunction

	function automatic void enter_stop();
		scl_q = 1'b0;
		sda_q = 1'b0;
		load_ticks(4);
		bus_phase = BP_STO_LOW;
	endfunction

	function automatic void shift_out_bit();
		sda_q = shift_q[BYTE_W-1];
		shift_q = {shift_q[BYTE_W-2:0], 1'b0};
		load_ticks(2);
		bus_phase = BP_WR_DATA;
	endfunction

	// One poll of the acknowledge; returns 1 when the sequence completes.
	function automatic bit poll_sda(input logic sda);
		if (!sda) begin
			scl_q = 1'b0;
			timeout_q = 1'b0;
			bus_phase = BP_IDLE;
			return 1'b1;
		end
		if (polls_seen >= POLL_LIMIT_DEF) begin
			timeout_q = 1'b1;
			enter_stop();
			return 1'b0;
		end
		polls_seen++;
		return 1'b0;
	endfunction

	// Advance a running sequence by one tick; returns 1 on completion.
	function automatic bit advance_bus(input logic sda);
		if (bus_phase == BP_IDLE)
			return 1'b0;
		if (bus_phase == BP_WAIT_POLL)
			return poll_sda(sda);
		if (ticks_left != '0)
			ticks_left--;
		if (ticks_left != '0)
			return 1'b0;
		case (bus_phase)
		BP_STA_HIGH: begin
			sda_q = 1'b0;
			load_ticks(4);
			bus_phase = BP_STA_LOW;
		end
		BP_STA_LOW: begin
			scl_q = 1'b0;
			bus_phase = BP_IDLE;
			return 1'b1;
		end
		BP_STO_LOW: begin
			scl_q = 1'b1;
			sda_q = 1'b1;
			load_ticks(4);
			bus_phase = BP_STO_HIGH;
		end
		BP_STO_HIGH: begin
			bus_phase = BP_IDLE;
			return 1'b1;
		end
		BP_WR_DATA: begin
			scl_q = 1'b1;
			load_ticks(2);
			bus_phase = BP_WR_SCLH;
		end
		BP_WR_SCLH: begin
			scl_q = 1'b0;
			load_ticks(2);
			bus_phase = BP_WR_SCLL;
		end
		BP_WR_SCLL: begin
			bits_done++;
			if (bits_done >= 8) begin
				bus_phase = BP_IDLE;
				return 1'b1;
			end
			shift_out_bit();
		end
		BP_RD_SCLL: begin
			scl_q = 1'b1;
			shift_q = {shift_q[BYTE_W-2:0], sda};
			load_ticks(1);
			bus_phase = BP_RD_SCLH;
		end
		BP_RD_SCLH: begin
			bits_done++;
			scl_q = 1'b0;
			load_ticks(2);
			if (bits_done < 8) begin
				bus_phase = BP_RD_SCLL;
			end else begin
				sda_q = !ack_low_q;
				bus_phase = BP_ACK_SCLL;
			end
		end
		BP_ACK_SCLL: begin
			scl_q = 1'b1;
			load_ticks(2);
			bus_phase = BP_ACK_SCLH;
		end
		BP_ACK_SCLH: begin
			scl_q = 1'b0;
			rx_byte_q = shift_q;
			bus_phase = BP_IDLE;
			return 1'b1;
		end
		BP_WAIT_SETUP: begin
			scl_q = 1'b1;
			load_ticks(1);
			bus_phase = BP_WAIT_SCLH;
		end
		BP_WAIT_SCLH: begin
			bus_phase = BP_WAIT_POLL;
			return poll_sda(sda);
		end
		default: bus_phase = BP_IDLE;
		endcase
		return 1'b0;
	endfunction

	// Work out the result beat that one accepted command beat causes.
	function automatic res_t next_bus_state(input cmd_t c);
		res_t r;
		bit   done;
		done = 1'b0;
		if (bus_phase == BP_IDLE && c.operation >= OP_START && c.operation <= OP_WACK) begin
			case (c.operation)
			OP_START: begin
				sda_q = 1'b1;
				scl_q = 1'b1;
				load_ticks(4);
				bus_phase = BP_STA_HIGH;
			end
			OP_STOP: enter_stop();
			OP_WRITE: begin
				scl_q = 1'b0;
				bits_done = '0;
				shift_q = c.write_data;
				shift_out_bit();
			end
			OP_READ: begin
				sda_q = 1'b1;
				scl_q = 1'b0;
				bits_done = '0;
				shift_q = '0;
				ack_low_q = c.send_ack;
				load_ticks(2);
				bus_phase = BP_RD_SCLL;
			end
			default: begin
				sda_q = 1'b1;
				polls_seen = '0;
				timeout_q = 1'b0;
				load_ticks(1);
				bus_phase = BP_WAIT_SETUP;
			end
			endcase
		end else begin
			done = advance_bus(c.sda_in);
		end
		r.scl_out    = scl_q;
		r.sda_out    = sda_q;
		r.busy_res   = (bus_phase != BP_IDLE);
		r.done_res   = done;
		r.read_data  = rx_byte_q;
		r.ack_failed = timeout_q;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Small delays keep sequences short; a few larger ones stretch them.
	function automatic logic [UNIT_W-1:0] pick_unit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return UNIT_W'(1);
		if (r < 65)
			return UNIT_W'(2);
		if (r < 80)
			return UNIT_W'(3);
		if (r < 95)
			return UNIT_W'($urandom_range(4, 8));
		return UNIT_W'($urandom_range(9, 16));
	endfunction

	// Offer one command beat, wait for the handshake and record its prediction.
	// Valid is dropped only when a gap follows, so back-to-back beats keep it high.
	task automatic send_beat(input cmd_t c);
		int gap;
		gap = jitter_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.operation  <= c.operation;
		cmd_ch.write_data <= c.write_data;
		cmd_ch.send_ack   <= c.send_ack;
		cmd_ch.sda_in     <= c.sda_in;
		do @(posedge clk); while (!cmd_ch.ready);
		if (bus_phase != BP_IDLE || (c.operation >= OP_START && c.operation <= OP_WACK))
			active_beats++;
		bus_state_q.push_back(next_bus_state(c));
	endtask

	// Issue one command from idle and tick until the predictor is idle again.
	// hold_high < 0 gives random SDA samples; otherwise SDA reads high for that
	// many ticks after the command and low from then on. With noise set, some
	// ticks carry a command, which a busy engine must ignore.
	task automatic run_sequence(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wdata,
			input logic sack, input int hold_high, input bit noise);
		cmd_t c;
		int   n;
		c.operation  = op;
		c.write_data = wdata;
		c.send_ack   = sack;
		c.sda_in     = 1'($urandom_range(0, 1));
		send_beat(c);
		n = 0;
		while (bus_phase != BP_IDLE) begin
			c.operation = OP_TICK;
			if (noise && $urandom_range(0, 5) == 0)
				c.operation = OP_W'($urandom_range(OP_START, OP_SPARE_HI));
			c.write_data = BYTE_W'($urandom);
			c.send_ack   = 1'($urandom_range(0, 1));
			c.sda_in     = (hold_high < 0) ? 1'($urandom_range(0, 1)) : (n < hold_high);
			send_beat(c);
			n++;
		end
	endtask

	// A beat that does nothing while idle: plain tick or a spare code.
	task automatic send_idle_noise();
		cmd_t c;
		c.operation = OP_W'($urandom_range(0, 2));
		if (c.operation != OP_TICK)
			c.operation = c.operation + OP_SPARE_LO - OP_W'(1);
		c.write_data = BYTE_W'($urandom);
		c.send_ack   = 1'($urandom_range(0, 1));
		c.sda_in     = 1'($urandom_range(0, 1));
		send_beat(c);
	endtask

	// Drop valid, wait for every predicted beat to arrive, then wait out the settle time.
	task automatic settle_idle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (bus_state_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_unit_delay(input logic [UNIT_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.unit_delay <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		unit_q = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Idle engine: ticks and spare codes with both SDA levels change nothing.
	task automatic test_idle_beats();
		repeat (4) send_idle_noise();
		settle_idle();
	endtask

	task automatic test_start_stop();
		write_unit_delay(UNIT_W'(1));
		run_sequence(OP_START, 8'h00, 1'b0, -1, 1'b0);
		run_sequence(OP_STOP, 8'hFF, 1'b1, -1, 1'b0);
		settle_idle();
	endtask

	// Write bytes of all zeros, all ones and 8'hA5; the last one
	// has commands thrown in while busy.
	task automatic test_write_byte();
		run_sequence(OP_WRITE, 8'h00, 1'b0, -1, 1'b0);
		run_sequence(OP_WRITE, 8'hFF, 1'b1, -1, 1'b0);
		run_sequence(OP_WRITE, 8'hA5, 1'b0, -1, 1'b1);
		settle_idle();
	endtask

	// Read all ones with ack, all zeros with nack, then random data.
	task automatic test_read_byte();
		run_sequence(OP_READ, 8'h00, 1'b1, 100000, 1'b0);
		run_sequence(OP_READ, 8'hFF, 1'b0, 0, 1'b0);
		run_sequence(OP_READ, 8'h5A, 1'b1, -1, 1'b1);
		settle_idle();
	endtask

	// At one tick per unit the polls start on the second tick after the
	// command: a low on the last allowed poll still passes, one tick later
	// the poll times out and a stop follows.
	task automatic test_wait_ack();
		write_unit_delay(UNIT_W'(1));
		run_sequence(OP_WACK, 8'h00, 1'b0, 0, 1'b0);
		run_sequence(OP_WACK, 8'h00, 1'b0, 10, 1'b1);
		run_sequence(OP_WACK, 8'h00, 1'b0, POLL_LIMIT_DEF + 1, 1'b0);
		run_sequence(OP_WACK, 8'h00, 1'b0, POLL_LIMIT_DEF + 2, 1'b0);
		// A read after a timeout leaves the flag, a clean poll clears it.
		run_sequence(OP_READ, 8'h00, 1'b0, -1, 1'b0);
		run_sequence(OP_WACK, 8'h00, 1'b0, 3, 1'b0);
		settle_idle();
	endtask

	// A long delay, then zero (counts as one), then a middle value.
	task automatic test_unit_delay_extremes();
		jitter_on = 1'b0;
		write_unit_delay(UNIT_W'(LONG_UNIT));
		run_sequence(OP_WACK, 8'h00, 1'b0, 0, 1'b0);
		settle_idle();
		jitter_on = 1'b1;
		write_unit_delay('0);
		run_sequence(OP_WRITE, 8'h3C, 1'b0, -1, 1'b0);
		run_sequence(OP_WACK, 8'h00, 1'b0, 2, 1'b0);
		settle_idle();
		write_unit_delay(UNIT_W'(5));
		run_sequence(OP_READ, 8'h00, 1'b1, -1, 1'b0);
		settle_idle();
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering
	// beats back to back, so the result register fills and command beats stall.
	task automatic test_result_backpressure();
		jitter_on = 1'b0;
		write_unit_delay(UNIT_W'(2));
		hold_off_req = 1'b1;
		run_sequence(OP_WRITE, 8'hC3, 1'b0, -1, 1'b0);
		run_sequence(OP_READ, 8'h00, 1'b0, -1, 1'b0);
		settle_idle();
		jitter_on = 1'b1;
	endtask

	// Random transactions: mostly well-formed commands with random content and
	// SDA, some idle noise, busy commands mixed in, and a new delay every few
	// sequences with jitter switched on or off.
	task automatic test_random_traffic();
		int base;
		int seq;
		int pick;
		int hold;
		base = active_beats;
		seq = 0;
		while (active_beats - base < RANDOM_BEATS) begin
			if (seq % 8 == 0) begin
				settle_idle();
				write_unit_delay(pick_unit());
				jitter_on = ($urandom_range(0, 3) != 0);
			end
			seq++;
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 3)) send_idle_noise();
			end else if (pick < 22) begin
				run_sequence(OP_START, BYTE_W'($urandom), 1'($urandom_range(0, 1)), -1,
					$urandom_range(0, 3) == 0);
			end else if (pick < 36) begin
				run_sequence(OP_STOP, BYTE_W'($urandom), 1'($urandom_range(0, 1)), -1,
					$urandom_range(0, 3) == 0);
			end else if (pick < 60) begin
				run_sequence(OP_WRITE, BYTE_W'($urandom), 1'($urandom_range(0, 1)), -1,
					$urandom_range(0, 3) == 0);
			end else if (pick < 80) begin
				hold = $urandom_range(0, 9);
				hold = (hold == 0) ? 0 : (hold == 1) ? 100000 : -1;
				run_sequence(OP_READ, BYTE_W'($urandom), 1'($urandom_range(0, 1)), hold,
					$urandom_range(0, 3) == 0);
			end else begin
				hold = $urandom_range(0, 99);
				if (hold < 50)
					hold = $urandom_range(0, 12);
				else if (hold < 75)
					hold = -1;
				else if (hold < 90)
					hold = $urandom_range(13, 60);
				else
					hold = $urandom_range(245, 260);
				run_sequence(OP_WACK, BYTE_W'($urandom), 1'($urandom_range(0, 1)), hold,
					$urandom_range(0, 3) == 0);
			end
		end
		settle_idle();
	endtask

	// Receiver: honour a long hold-off request, otherwise stall at random while jitter is on.
	initial begin
		int wait_left;
		wait_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				wait_left = LONG_HOLD;
			end
			if (wait_left > 0) begin
				res_ch.ready <= 1'b0;
				wait_left--;
			end else if (jitter_on && res_ch.ready && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				wait_left = pick_gap();
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compare each result beat with the oldest prediction, field by field.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (bus_state_q.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual scl %0b sda %0b",
					$time, res_ch.scl_out, res_ch.sda_out);
				errors++;
			end else begin
				want = bus_state_q.pop_front();
				check_field("scl_out", 32'(want.scl_out), 32'(res_ch.scl_out));
				check_field("sda_out", 32'(want.sda_out), 32'(res_ch.sda_out));
				check_field("busy_res", 32'(want.busy_res), 32'(res_ch.busy_res));
				check_field("done_res", 32'(want.done_res), 32'(res_ch.done_res));
				check_field("read_data", 32'(want.read_data), 32'(res_ch.read_data));
				check_field("ack_failed", 32'(want.ack_failed), 32'(res_ch.ack_failed));
			end
		end
	end

	// Watchdog: give up when no beat moves on any channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("i2c_master_byte_engine_unit test failed");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.operation  = OP_TICK;
		cmd_ch.write_data = '0;
		cmd_ch.send_ack   = 1'b0;
		cmd_ch.sda_in     = 1'b1;
		cfg_ch.valid      = 1'b0;
		cfg_ch.unit_delay = UNIT_DELAY_RST;
		errors            = 0;
		active_beats      = 0;
		jitter_on         = 1'b1;
		hold_off_req      = 1'b0;
		reset_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_beats();
		test_start_stop();
		test_write_byte();
		test_read_byte();
		test_wait_ack();
		test_unit_delay_extremes();
		test_result_backpressure();
		test_random_traffic();

		if (errors == 0)
			$display("i2c_master_byte_engine_unit test passed");
		else
			$display("i2c_master_byte_engine_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_core.sv
rtl/i2c_master_byte_engine_unit.sv
sim/i2c_master_byte_engine_unit_tb.sv
